[hdl/mer_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mer_pkg
// Shared widths, codes and the control/status bundles of the midpoint
// ellipse rasterizer.
// ----------------------------------------------------------------------------
package mer_pkg;

  localparam int CW   = 12;           // input coordinate width
  localparam int OW   = CW + 2;       // output coordinate width
  localparam int SQW  = 2 * CW;       // squared radius width
  localparam int CURW = CW + 1;       // current offset width (signed)
  localparam int MW   = 2 * CW + 4;   // multiplier operand width
  localparam int DW   = 2 * MW;       // decision / product width
  localparam int STW  = 3 * CW + 4;   // incremental term width (signed)

  localparam logic KIND_START   = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  typedef enum logic [2:0] {
    MUL_RX_RX,
    MUL_RY_RY,
    MUL_RX2_RY,
    MUL_SQX,
    MUL_SQY,
    MUL_RY2_TA,
    MUL_RX2_TB,
    MUL_RX2_RY2
  } mul_sel_t;

  typedef enum logic [3:0] {
    WB_NONE,
    WB_RX2,
    WB_RY2,
    WB_START,
    WB_TMPA,
    WB_TMPB,
    WB_ACC_INIT,
    WB_ACC_ADD,
    WB_R2_FIN
  } wb_sel_t;

  typedef struct packed {
    logic     load_start;
    logic     step1;
    logic     step2;
    mul_sel_t mul_sel;
    wb_sel_t  wb_sel;
    logic     load_out;
    logic     out_zero;
  } cmd_t;

  typedef struct packed {
    logic region_two;
    logic step_lt;
    logic y_le_zero;
  } status_t;

  // quarter units to whole units, truncated toward zero
  function automatic logic [DW-1:0] qtrunc(input logic [DW-1:0] q);
    logic [DW-1:0] b;
    b = q + (q[DW-1] ? DW'(3) : '0);
    return {b[DW-1], b[DW-1], b[DW-1:2]};
  endfunction

endpackage
`default_nettype wire

[hdl/mer_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mer_in_if
// Input channel: start or advance beats with centre and edge point.
// ----------------------------------------------------------------------------
interface mer_in_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic signed [mer_pkg::CW-1:0] center_x;
  logic signed [mer_pkg::CW-1:0] center_y;
  logic signed [mer_pkg::CW-1:0] edge_x;
  logic signed [mer_pkg::CW-1:0] edge_y;

  modport source (output valid, kind, center_x, center_y, edge_x, edge_y, input ready);
  modport sink (input valid, kind, center_x, center_y, edge_x, edge_y, output ready);
endinterface
`default_nettype wire

[hdl/mer_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mer_out_if
// Result channel: four symmetric coordinates plus flags per beat.
// ----------------------------------------------------------------------------
interface mer_out_if;
  logic                         valid;
  logic                         ready;
  logic signed [mer_pkg::OW-1:0] x_plus;
  logic signed [mer_pkg::OW-1:0] x_minus;
  logic signed [mer_pkg::OW-1:0] y_plus;
  logic signed [mer_pkg::OW-1:0] y_minus;
  logic                         valid_res;
  logic                         last;

  modport source (output valid, x_plus, x_minus, y_plus, y_minus, valid_res, last,
                  input ready);
  modport sink (input valid, x_plus, x_minus, y_plus, y_minus, valid_res, last,
                output ready);
endinterface
`default_nettype wire

[hdl/mer_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mer_dp
// Ellipse datapath: radii, squared radii, offsets, decision and step terms,
// one shared multiplier with registered product, and the output register.
// ----------------------------------------------------------------------------
module mer_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic signed [mer_pkg::CW-1:0]  in_center_x,
  input  wire logic signed [mer_pkg::CW-1:0]  in_center_y,
  input  wire logic signed [mer_pkg::CW-1:0]  in_edge_x,
  input  wire logic signed [mer_pkg::CW-1:0]  in_edge_y,
  input  wire mer_pkg::cmd_t                  cmd,
  output mer_pkg::status_t                    st,
  output logic signed [mer_pkg::OW-1:0]       out_x_plus,
  output logic signed [mer_pkg::OW-1:0]       out_x_minus,
  output logic signed [mer_pkg::OW-1:0]       out_y_plus,
  output logic signed [mer_pkg::OW-1:0]       out_y_minus,
  output logic                                out_valid_res,
  output logic                                out_last
);

  localparam int CW   = mer_pkg::CW;
  localparam int OW   = mer_pkg::OW;
  localparam int SQW  = mer_pkg::SQW;
  localparam int CURW = mer_pkg::CURW;
  localparam int MW   = mer_pkg::MW;
  localparam int DW   = mer_pkg::DW;
  localparam int STW  = mer_pkg::STW;

  logic signed [CW-1:0]   mid_x_r, mid_y_r;
  logic [CW-1:0]          rx_r, ry_r;
  logic [SQW-1:0]         rx2_r, ry2_r;
  logic signed [CURW-1:0] cur_x_r, cur_y_r;
  logic [DW-1:0]          dec_r, acc_r, prod_r;
  logic [STW-1:0]         stx_r, sty_r;
  logic [MW-1:0]          ta_r, tb_r;
  logic                   reg2_r;

  logic signed [OW-1:0]   xp_r, xm_r, yp_r, ym_r;
  logic                   vres_r, last_r;

  logic signed [CW:0]     dx, dy;
  logic [CW-1:0]          rx_in, ry_in;
  logic signed [CW+1:0]   ym1;
  logic [CW+1:0]          ym1_abs;
  logic [MW-1:0]          mul_a, mul_b;
  logic                   dec_neg, dec_pos;
  logic [STW-1:0]         stx_up, sty_dn;
  logic [DW-1:0]          stx_ext, sty_ext, dec_step;
  logic [DW-1:0]          start_q, prod_x4;
  logic signed [OW-1:0]   mx_ext, my_ext, cx_ext, cy_ext;
  logic                   last_now;

  // radii from the start beat
  assign dx    = {in_edge_x[CW-1], in_edge_x} - {in_center_x[CW-1], in_center_x};
  assign dy    = {in_edge_y[CW-1], in_edge_y} - {in_center_y[CW-1], in_center_y};
  assign rx_in = dx[CW] ? CW'(-dx) : dx[CW-1:0];
  assign ry_in = dy[CW] ? CW'(-dy) : dy[CW-1:0];

  assign ym1     = {cur_y_r[CURW-1], cur_y_r} - (CW+2)'(1);
  assign ym1_abs = ym1[CW+1] ? -ym1 : ym1;

  always_comb begin
    mul_a = MW'(rx_r);
    mul_b = MW'(rx_r);
    case (cmd.mul_sel)
      mer_pkg::MUL_RX_RX:   begin mul_a = MW'(rx_r);  mul_b = MW'(rx_r);  end
      mer_pkg::MUL_RY_RY:   begin mul_a = MW'(ry_r);  mul_b = MW'(ry_r);  end
      mer_pkg::MUL_RX2_RY:  begin mul_a = MW'(rx2_r); mul_b = MW'(ry_r);  end
      mer_pkg::MUL_SQX: begin
        mul_a = MW'({cur_x_r, 1'b1});
        mul_b = MW'({cur_x_r, 1'b1});
      end
      mer_pkg::MUL_SQY:     begin mul_a = MW'(ym1_abs); mul_b = MW'(ym1_abs); end
      mer_pkg::MUL_RY2_TA:  begin mul_a = MW'(ry2_r); mul_b = ta_r; end
      mer_pkg::MUL_RX2_TB:  begin mul_a = MW'(rx2_r); mul_b = tb_r; end
      mer_pkg::MUL_RX2_RY2: begin mul_a = MW'(rx2_r); mul_b = MW'(ry2_r); end
      default:              begin mul_a = MW'(rx_r);  mul_b = MW'(rx_r);  end
    endcase
  end

  assign dec_neg = dec_r[DW-1];
  assign dec_pos = !dec_neg && (|dec_r);

  assign stx_up  = stx_r + STW'({ry2_r, 1'b0});
  assign sty_dn  = sty_r - STW'({rx2_r, 1'b0});
  assign stx_ext = {{(DW-STW){stx_r[STW-1]}}, stx_r};
  assign sty_ext = {{(DW-STW){sty_r[STW-1]}}, sty_r};

  // step terms were updated in the cycle before, so these are the new values
  always_comb begin
    if (!reg2_r) begin
      dec_step = dec_r + DW'(ry2_r) + stx_ext - (dec_neg ? '0 : sty_ext);
    end else begin
      dec_step = dec_r + DW'(rx2_r) - sty_ext + (dec_pos ? '0 : stx_ext);
    end
  end

  assign prod_x4 = {prod_r[DW-3:0], 2'b00};
  assign start_q = DW'(2) + DW'({ry2_r, 2'b00}) - prod_x4 + DW'(rx2_r);

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;

    if (cmd.load_start) begin
      mid_x_r <= in_center_x;
      mid_y_r <= in_center_y;
      rx_r    <= rx_in;
      ry_r    <= ry_in;
      cur_x_r <= '0;
      cur_y_r <= CURW'(ry_in);
      stx_r   <= '0;
    end

    if (cmd.step1) begin
      if (!reg2_r) begin
        cur_x_r <= cur_x_r + CURW'(1);
        stx_r   <= stx_up;
        if (!dec_neg) begin
          cur_y_r <= cur_y_r - CURW'(1);
          sty_r   <= sty_dn;
        end
      end else begin
        cur_y_r <= cur_y_r - CURW'(1);
        sty_r   <= sty_dn;
        if (!dec_pos) begin
          cur_x_r <= cur_x_r + CURW'(1);
          stx_r   <= stx_up;
        end
      end
    end

    if (cmd.step2) begin
      dec_r <= dec_step;
    end

    case (cmd.wb_sel)
      mer_pkg::WB_RX2:      rx2_r <= prod_r[SQW-1:0];
      mer_pkg::WB_RY2:      ry2_r <= prod_r[SQW-1:0];
      mer_pkg::WB_START: begin
        sty_r <= {prod_r[STW-2:0], 1'b0};
        dec_r <= mer_pkg::qtrunc(start_q);
      end
      mer_pkg::WB_TMPA:     ta_r  <= prod_r[MW-1:0];
      mer_pkg::WB_TMPB:     tb_r  <= prod_r[MW-1:0];
      mer_pkg::WB_ACC_INIT: acc_r <= DW'(2) + prod_r;
      mer_pkg::WB_ACC_ADD:  acc_r <= acc_r + prod_x4;
      mer_pkg::WB_R2_FIN:   dec_r <= mer_pkg::qtrunc(acc_r - prod_x4);
      default: ;
    endcase

    if (cmd.load_out) begin
      xp_r   <= cmd.out_zero ? '0 : mx_ext + cx_ext;
      xm_r   <= cmd.out_zero ? '0 : mx_ext - cx_ext;
      yp_r   <= cmd.out_zero ? '0 : my_ext + cy_ext;
      ym_r   <= cmd.out_zero ? '0 : my_ext - cy_ext;
      vres_r <= !cmd.out_zero;
      last_r <= !cmd.out_zero && last_now;
    end
  end

  // region flag is control state: cleared by reset and on every start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg2_r <= 1'b0;
    end else if (cmd.load_start) begin
      reg2_r <= 1'b0;
    end else if (cmd.wb_sel == mer_pkg::WB_R2_FIN) begin
      reg2_r <= 1'b1;
    end
  end

  assign mx_ext = {{(OW-CW){mid_x_r[CW-1]}}, mid_x_r};
  assign my_ext = {{(OW-CW){mid_y_r[CW-1]}}, mid_y_r};
  assign cx_ext = {{(OW-CURW){cur_x_r[CURW-1]}}, cur_x_r};
  assign cy_ext = {{(OW-CURW){cur_y_r[CURW-1]}}, cur_y_r};

  assign last_now = reg2_r && st.y_le_zero;

  assign st.region_two = reg2_r;
  assign st.step_lt    = $signed(stx_r) < $signed(sty_r);
  assign st.y_le_zero  = cur_y_r <= 0;

  assign out_x_plus    = xp_r;
  assign out_x_minus   = xm_r;
  assign out_y_plus    = yp_r;
  assign out_y_minus   = ym_r;
  assign out_valid_res = vres_r;
  assign out_last      = last_r;

endmodule
`default_nettype wire

[hdl/mer_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mer_ctrl
// Sequencer: accepts beats, orders the multiplies of start and region
// change, runs the step as step1 then step2 and hands results to the output register.
// ----------------------------------------------------------------------------
module mer_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_kind,
  output logic                  in_ready,
  input  wire logic             out_ready,
  output logic                  out_valid,
  input  wire mer_pkg::status_t st,
  output mer_pkg::cmd_t         cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_M_RX,
    ST_M_RY,
    ST_M_RXRY,
    ST_S_FIN,
    ST_SETTLE,
    ST_R2_SQX,
    ST_R2_SQY,
    ST_R2_P1,
    ST_R2_P2,
    ST_R2_P3,
    ST_R2_FIN,
    ST_STEP2,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   zero_r, zero_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept, slot_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    busy_nxt      = busy_r;
    zero_nxt      = zero_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '{load_start: 1'b0, step1: 1'b0, step2: 1'b0,
                      mul_sel: mer_pkg::MUL_RX_RX, wb_sel: mer_pkg::WB_NONE,
                      load_out: 1'b0, out_zero: 1'b0};
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == mer_pkg::KIND_START) begin
            cmd.load_start = 1'b1;
            zero_nxt       = 1'b0;
            state_nxt      = ST_M_RX;
          end else if (busy_r) begin
            cmd.step1 = 1'b1;
            zero_nxt  = 1'b0;
            state_nxt = ST_STEP2;
          end else begin
            zero_nxt  = 1'b1;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_M_RX: begin
        cmd.mul_sel = mer_pkg::MUL_RX_RX;
        state_nxt   = ST_M_RY;
      end
      ST_M_RY: begin
        cmd.mul_sel = mer_pkg::MUL_RY_RY;
        cmd.wb_sel  = mer_pkg::WB_RX2;
        state_nxt   = ST_M_RXRY;
      end
      ST_M_RXRY: begin
        cmd.mul_sel = mer_pkg::MUL_RX2_RY;
        cmd.wb_sel  = mer_pkg::WB_RY2;
        state_nxt   = ST_S_FIN;
      end
      ST_S_FIN: begin
        cmd.wb_sel = mer_pkg::WB_START;
        state_nxt  = ST_SETTLE;
      end
      ST_SETTLE: begin
        state_nxt = (!st.region_two && !st.step_lt) ? ST_R2_SQX : ST_EMIT;
      end
      ST_R2_SQX: begin
        cmd.mul_sel = mer_pkg::MUL_SQX;
        state_nxt   = ST_R2_SQY;
      end
      ST_R2_SQY: begin
        cmd.mul_sel = mer_pkg::MUL_SQY;
        cmd.wb_sel  = mer_pkg::WB_TMPA;
        state_nxt   = ST_R2_P1;
      end
      ST_R2_P1: begin
        cmd.mul_sel = mer_pkg::MUL_RY2_TA;
        cmd.wb_sel  = mer_pkg::WB_TMPB;
        state_nxt   = ST_R2_P2;
      end
      ST_R2_P2: begin
        cmd.mul_sel = mer_pkg::MUL_RX2_TB;
        cmd.wb_sel  = mer_pkg::WB_ACC_INIT;
        state_nxt   = ST_R2_P3;
      end
      ST_R2_P3: begin
        cmd.mul_sel = mer_pkg::MUL_RX2_RY2;
        cmd.wb_sel  = mer_pkg::WB_ACC_ADD;
        state_nxt   = ST_R2_FIN;
      end
      ST_R2_FIN: begin
        cmd.wb_sel = mer_pkg::WB_R2_FIN;
        state_nxt  = ST_EMIT;
      end
      ST_STEP2: begin
        // step terms are fresh here, so the region test needs no settle state
        cmd.step2 = 1'b1;
        state_nxt = (!st.region_two && !st.step_lt) ? ST_R2_SQX : ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          cmd.out_zero  = zero_r;
          out_valid_nxt = 1'b1;
          if (!zero_r) begin
            busy_nxt = !(st.region_two && st.y_le_zero);
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      busy_r      <= 1'b0;
      zero_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      zero_r      <= zero_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

[hdl/midpoint_ellipse_rasterizer_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_core
// Pull-driven axis-aligned midpoint ellipse generator, one result beat per
// input beat.
// ----------------------------------------------------------------------------
// A start beat latches the centre, takes the radii as |edge - centre| and
// returns the four points at offset (0, ry); each advance beat runs one
// midpoint step and returns the next four points, with last set on the
// final set, after which the block is idle and an advance returns an all
// zero beat with valid_res low. A start, and a step that enters region 2,
// run their multiplies in turn through the single 28x28 multiplier, which
// yields one registered product per cycle for the squared radii, the
// start terms and the region 2 decision seed. Input is taken only
// when the sequencer is idle; a finished result waits in the output
// register and the next beat is accepted meanwhile, so a stalled output
// adds cycles only when a second result is ready behind it.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_core (
  input  wire logic clk,
  input  wire logic rst_n,
  mer_in_if.sink    in_ch,
  mer_out_if.source out_ch
);

  mer_pkg::cmd_t    cmd;
  mer_pkg::status_t st;

  mer_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_kind   (in_ch.kind),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .st        (st),
    .cmd       (cmd)
  );

  mer_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_center_x   (in_ch.center_x),
    .in_center_y   (in_ch.center_y),
    .in_edge_x     (in_ch.edge_x),
    .in_edge_y     (in_ch.edge_y),
    .cmd           (cmd),
    .st            (st),
    .out_x_plus    (out_ch.x_plus),
    .out_x_minus   (out_ch.x_minus),
    .out_y_plus    (out_ch.y_plus),
    .out_y_minus   (out_ch.y_minus),
    .out_valid_res (out_ch.valid_res),
    .out_last      (out_ch.last)
  );

`ifndef SYNTHESIS
  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_ch.valid || out_ch.ready))
    else $error("output register loaded while a result beat is pending");

  // last only ever marks a real point set
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.last) |-> out_ch.valid_res)
    else $error("last flag on a beat without valid points");

  // a start always begins in region 1
  a_start_region: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.kind == mer_pkg::KIND_START))
      |=> !st.region_two)
    else $error("region flag not cleared by start beat");
`endif

endmodule
`default_nettype wire
